// ===== rtl/crc16pa_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16pa_pkg
// Shared types, constants and the byte-wise CRC-16 update for the packet
// append/check unit.
// ----------------------------------------------------------------------------
package crc16pa_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [1:0]  MIN_LEN   = 2'd2;

    // Result queue: deep enough for the three results of one byte plus one in
    // flight, so a packet's bytes go at one per cycle unless the output stalls.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH   = 3;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_SHORT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       end_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r2;
        result_t    r1;
        result_t    r0;
    } push_t;

    // MSB-first CRC-16 update over one byte, eight shift steps.
    function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc16pa_if.sv =====
// ----------------------------------------------------------------------------
// crc16pa_if
// Valid/ready channels for incoming packet bytes and outgoing results.
// ----------------------------------------------------------------------------
interface crc16pa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16pa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       end_of_run;

    modport source (output valid, output out_byte, output kind, output end_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input end_of_run,
                    output ready);
endinterface

// ===== rtl/crc16_packet_append_check_unit.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_append_check_unit
// CRC-16 (poly 0x1021, init 0, MSB first) packet framer and checker.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while input ready is high. In append mode
// every byte is passed on and the last byte is followed by the CRC, high byte
// first; in check mode only a verdict (good, bad CRC, too short) comes out at
// the last byte. The CRC of a byte is computed in the accept cycle and its
// results are written to the four-entry result queue at its end, so a result
// can be offered the cycle after its request is taken. Input ready stays high
// while the queue holds at most one result; a packet of N bytes in append
// mode gives N+2 results. check_mode may change only while the unit is idle.
// ----------------------------------------------------------------------------
module crc16_packet_append_check_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    crc16pa_in_if.sink      in_ch,
    crc16pa_out_if.source   out_ch
);

    logic                 mode_reg;
    logic                 mode_next;
    logic                 room;
    logic                 accept;
    crc16pa_pkg::push_t   push;
    crc16pa_pkg::result_t head;

    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    crc16pa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_mode (mode_reg),
        .accept     (accept),
        .data_byte  (in_ch.data_byte),
        .last_byte  (in_ch.last_byte),
        .push       (push)
    );

    crc16pa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (head)
    );

    assign out_ch.out_byte   = head.out_byte;
    assign out_ch.kind       = head.kind;
    assign out_ch.end_of_run = head.end_of_run;

endmodule

// ===== rtl/crc16pa_engine.sv =====
// ----------------------------------------------------------------------------
// crc16pa_engine
// Running CRC and length count; turns each accepted byte into up to three
// results for the result queue.
// ----------------------------------------------------------------------------
module crc16pa_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                check_mode,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output crc16pa_pkg::push_t  push
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [1:0]  seen_reg;
    logic [1:0]  seen_next;
    logic [15:0] crc_upd;
    logic [1:0]  seen_upd;
    crc16pa_pkg::kind_t verdict;

    assign crc_upd  = crc16pa_pkg::crc_step(crc_reg, data_byte);
    assign seen_upd = (seen_reg < crc16pa_pkg::MIN_LEN) ? seen_reg + 2'd1 : seen_reg;

    always_comb
    begin
        if (seen_upd < crc16pa_pkg::MIN_LEN)
        begin
            verdict = crc16pa_pkg::KIND_SHORT;
        end
        else if (crc_upd == 16'h0000)
        begin
            verdict = crc16pa_pkg::KIND_GOOD;
        end
        else
        begin
            verdict = crc16pa_pkg::KIND_BAD;
        end
    end

    always_comb
    begin
        push.r0 = '{out_byte: data_byte, kind: crc16pa_pkg::KIND_DATA, end_of_run: 1'b0};
        push.r1 = '{out_byte: crc_upd[15:8], kind: crc16pa_pkg::KIND_DATA,
                    end_of_run: 1'b0};
        push.r2 = '{out_byte: crc_upd[7:0], kind: crc16pa_pkg::KIND_DATA,
                    end_of_run: 1'b1};
        push.n  = 2'd0;
        if (accept)
        begin
            if (!check_mode)
            begin
                push.n = last_byte ? 2'd3 : 2'd1;
            end
            else if (last_byte)
            begin
                // one verdict, carrying no byte
                push.r0 = '{out_byte: 8'h00, kind: verdict, end_of_run: 1'b1};
                push.n  = 2'd1;
            end
        end
    end

    always_comb
    begin
        crc_next  = crc_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            crc_next  = last_byte ? 16'h0000 : crc_upd;
            seen_next = last_byte ? 2'd0 : seen_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= 16'h0000;
            seen_reg <= 2'd0;
        end
        else
        begin
            crc_reg  <= crc_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== rtl/crc16pa_fifo.sv =====
// ----------------------------------------------------------------------------
// crc16pa_fifo
// Result queue: takes up to three results a cycle, gives one a cycle if ready.
// ----------------------------------------------------------------------------
module crc16pa_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  crc16pa_pkg::push_t  push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output crc16pa_pkg::result_t out_data
);

    crc16pa_pkg::result_t            mem_reg [crc16pa_pkg::FIFO_DEPTH];
    logic [crc16pa_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [crc16pa_pkg::PTR_W-1:0]   wr_ptr_next;
    logic [crc16pa_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [crc16pa_pkg::PTR_W-1:0]   rd_ptr_next;
    logic [crc16pa_pkg::CNT_W-1:0]   count_reg;
    logic [crc16pa_pkg::CNT_W-1:0]   count_next;
    crc16pa_pkg::result_t            wr_data [crc16pa_pkg::MAX_PUSH];
    logic                            pop;

    assign wr_data[0] = push.r0;
    assign wr_data[1] = push.r1;
    assign wr_data[2] = push.r2;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // accept a byte only when a full burst of results still fits
    assign room      = (count_reg <= crc16pa_pkg::CNT_W'(crc16pa_pkg::FIFO_DEPTH
                                                         - crc16pa_pkg::MAX_PUSH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + crc16pa_pkg::PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + crc16pa_pkg::PTR_W'(pop);
        count_next  = count_reg + crc16pa_pkg::CNT_W'(push.n)
                      - crc16pa_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < crc16pa_pkg::MAX_PUSH; i++)
        begin
            if (2'(i) < push.n)
            begin
                mem_reg[wr_ptr_reg + crc16pa_pkg::PTR_W'(i)] <= wr_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/crc16pa_checker.sv =====
// ----------------------------------------------------------------------------
// crc16pa_checker
// Port-level checks on the packet unit's result stream.
// ----------------------------------------------------------------------------
module crc16pa_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic [1:0] kind,
    input  logic       end_of_run
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind))
        else $error("result dropped while stalled");

    // a verdict always closes the packet
    a_verdict_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != crc16pa_pkg::KIND_DATA) |-> end_of_run)
        else $error("verdict without end of run");

    // a verdict carries no byte
    a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != crc16pa_pkg::KIND_DATA) |-> (out_byte == 8'h00))
        else $error("verdict with non-zero byte");

    // an offered result never carries unknown bits
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_byte, kind, end_of_run}))
        else $error("unknown result bits");

endmodule

bind crc16_packet_append_check_unit crc16pa_checker u_crc16pa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .kind       (out_ch.kind),
    .end_of_run (out_ch.end_of_run)
);

// ===== tb/crc16pa_frame_checker.sv =====
// ----------------------------------------------------------------------------
// crc16pa_frame_checker
// Watches the byte and result channels of the CRC-16 append/check unit,
// keeps its own running CRC, byte count and mode, and compares each result
// taken from the unit with the oldest one it has worked out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16pa_frame_checker (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    crc16pa_in_if   in_mon,
    crc16pa_out_if  out_mon,
    output int      fail_count,
    output int      pending,
    output int      result_count,
    output int      verdict_count
);

    logic [15:0]          frame_crc;
    logic [1:0]           bytes_taken;
    logic                 check_on;
    crc16pa_pkg::result_t due_results[$];
    int                   bad_results;
    int                   taken;
    int                   verdicts;

    // Bit-serial form: feed each data bit into the top of the register.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ crc16pa_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic predict_request(input logic [7:0] b, input logic last);
        crc16pa_pkg::kind_t verdict;
        frame_crc = crc16_next(frame_crc, b);
        if (bytes_taken < crc16pa_pkg::MIN_LEN)
        begin
            bytes_taken = bytes_taken + 2'd1;
        end
        if (!check_on)
        begin
            due_results.push_back(crc16pa_pkg::result_t'{out_byte: b,
                                  kind: crc16pa_pkg::KIND_DATA, end_of_run: 1'b0});
            if (last)
            begin
                due_results.push_back(crc16pa_pkg::result_t'{out_byte: frame_crc[15:8],
                                      kind: crc16pa_pkg::KIND_DATA, end_of_run: 1'b0});
                due_results.push_back(crc16pa_pkg::result_t'{out_byte: frame_crc[7:0],
                                      kind: crc16pa_pkg::KIND_DATA, end_of_run: 1'b1});
            end
        end
        else if (last)
        begin
            if (bytes_taken < crc16pa_pkg::MIN_LEN)
            begin
                verdict = crc16pa_pkg::KIND_SHORT;
            end
            else if (frame_crc == 16'h0000)
            begin
                verdict = crc16pa_pkg::KIND_GOOD;
            end
            else
            begin
                verdict = crc16pa_pkg::KIND_BAD;
            end
            due_results.push_back(crc16pa_pkg::result_t'{out_byte: 8'h00, kind: verdict,
                                  end_of_run: 1'b1});
            verdicts++;
        end
        // Clear the packet state once the marked byte has gone in
        if (last)
        begin
            frame_crc   = 16'h0000;
            bytes_taken = 2'd0;
        end
    endtask

    task automatic check_result();
        crc16pa_pkg::result_t want;
        taken++;
        if (due_results.size() == 0)
        begin
            bad_results++;
            if (bad_results <= 10)
            begin
                $display("[%0t] unexpected result: byte %02h kind %0d end %0b", $realtime,
                         out_mon.out_byte, out_mon.kind, out_mon.end_of_run);
            end
        end
        else
        begin
            want = due_results.pop_front();
            if (out_mon.out_byte !== want.out_byte || out_mon.kind !== want.kind
                || out_mon.end_of_run !== want.end_of_run)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display("[%0t] mismatch: expected %02h/%0d/%0b got %02h/%0d/%0b",
                             $realtime, want.out_byte, want.kind, want.end_of_run,
                             out_mon.out_byte, out_mon.kind, out_mon.end_of_run);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_crc   = 16'h0000;
            bytes_taken = 2'd0;
            check_on    = 1'b0;
            bad_results = 0;
            taken       = 0;
            verdicts    = 0;
            due_results.delete();
            fail_count    <= 0;
            pending       <= 0;
            result_count  <= 0;
            verdict_count <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                predict_request(in_mon.data_byte, in_mon.last_byte);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                check_result();
            end
            // The mode written at this edge applies from the next request on
            if (cfg_wr_en)
            begin
                check_on = cfg_wr_data;
            end
            fail_count    <= bad_results;
            pending       <= due_results.size();
            result_count  <= taken;
            verdict_count <= verdicts;
        end
    end

endmodule

// ===== tb/crc16_packet_append_check_unit_tb.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_append_check_unit_tb
// Drives packets through the CRC-16 append/check unit in both modes: short,
// good, corrupted and random packets, mode changes inside a packet, random
// gaps on both channels and one long output stall. The checker beside the
// unit predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_packet_append_check_unit_tb;

    localparam logic MODE_APPEND   = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;
    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   RANDOM_ITEMS  = 160;
    localparam int   HOLD_CYCLES   = 80;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   IDLE_PCT      = 11;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic quiet;
    int   hold_asked;
    int   cycles = 0;
    int   items_sent;
    int   mode_writes;
    int   fail_count;
    int   pending;
    int   result_count;
    int   verdict_count;
    logic [7:0] frame[$];

    crc16pa_in_if  in_ch();
    crc16pa_out_if out_ch();

    crc16_packet_append_check_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    crc16pa_frame_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .verdict_count (verdict_count)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked
    initial
    begin
        int hold_left;
        int hold_done;
        hold_left    = 0;
        hold_done    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        c = 16'h0000;
        foreach (frame[k])
        begin
            c = c ^ {frame[k], 8'h00};
            for (int i = 0; i < 8; i++)
            begin
                c = c[15] ? ({c[14:0], 1'b0} ^ crc16pa_pkg::CRC_POLY) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Leaves valid high on return; the caller either offers the next request
    // in the same step or drops valid.
    task automatic send_request(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[k])
        begin
            send_request(frame[k], k == frame.size() - 1);
        end
    endtask

    task automatic seal_frame();
        logic [15:0] c;
        c = frame_crc();
        frame.push_back(c[15:8]);
        frame.push_back(c[7:0]);
    endtask

    // Drop valid, wait for every due result, then let the pipeline settle
    task automatic go_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_writes++;
    endtask

    task automatic build_frame(input logic m);
        int len;
        int pick;
        int k;
        frame.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
        repeat (len) frame.push_back(8'($urandom_range(0, 255)));
        if (m == MODE_CHECK)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                seal_frame();
            end
            // Flip one bit anywhere in a sealed packet
            if (pick >= 65 && pick < 80)
            begin
                k = $urandom_range(0, frame.size() - 1);
                frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        if (frame.size() == 0)
        begin
            frame.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int   random_start;
        int   phase;
        logic m;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        quiet           = 1'b0;
        hold_asked      = 0;
        items_sent      = 0;
        mode_writes     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Append mode from reset: one-byte packet, byte extremes, three bytes
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h80, 1'b1);
        send_request(8'h01, 1'b0);
        send_request(8'h7F, 1'b0);
        send_request(8'hAA, 1'b1);
        go_idle();

        set_mode(MODE_CHECK);
        // Too short, with a non-zero and then a zero CRC
        send_request(8'h55, 1'b1);
        send_request(8'h00, 1'b1);
        // Shortest good packet
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b1);
        frame = {8'h31, 8'h32, 8'h33};
        seal_frame();
        send_frame();
        frame[1] = frame[1] ^ 8'h10;
        send_frame();
        // Change mode inside a packet, both ways; the CRC carries on
        send_request(8'hC3, 1'b0);
        send_request(8'h3C, 1'b0);
        go_idle();
        set_mode(MODE_APPEND);
        send_request(8'h5A, 1'b0);
        go_idle();
        set_mode(MODE_CHECK);
        send_request(8'hA5, 1'b1);
        go_idle();

        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            m = ($urandom_range(0, 1) == 1) ? MODE_CHECK : MODE_APPEND;
            if (phase == 1)
            begin
                // Long output stall while append traffic keeps coming
                m = MODE_APPEND;
                hold_asked <= hold_asked + 1;
            end
            quiet <= (phase == 2);
            set_mode(m);
            repeat ($urandom_range(3, 6))
            begin
                build_frame(m);
                send_frame();
            end
            // Now and then leave a packet open across the mode write
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            go_idle();
            phase++;
        end
        quiet <= 1'b0;
        repeat (8) @(posedge clk);

        $display("%0d bytes over %0d phases, %0d mode writes", items_sent, phase, mode_writes);
        $display("%0d results taken, %0d of them check verdicts, %0d mismatched",
                 result_count, verdict_count, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
